// ----- rtl/window_nonmax_suppression_defines.svh -----
// ============================================================================
// window_nonmax_suppression_defines.svh
// Assertion macros shared by the non-maximum suppression RTL.
// ============================================================================
`ifndef WINDOW_NONMAX_SUPPRESSION_DEFINES_SVH
`define WINDOW_NONMAX_SUPPRESSION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WNS_ASSERT_IMPL(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("window_nonmax_suppression: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WNS_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("window_nonmax_suppression: next-cycle check failed");

// The condition must hold in the cycle after reset was sampled high.
`define WNS_ASSERT_AFTER_RESET(label, clk, rst, cond) \
   label: assert property (@(posedge clk) (rst) |=> (cond)) \
      else $error("window_nonmax_suppression: post-reset check failed");

`endif

// ----- rtl/wns_pkg.sv -----
// ============================================================================
// wns_pkg
// Shared constants and types of the windowed non-maximum suppression block.
// ============================================================================
package wns_pkg;

   // Geometry of the window and of the image.
   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 1024;
   localparam int WINDOW     = 7;
   localparam int HALF       = WINDOW / 2;
   localparam int LINES      = WINDOW - 1;
   localparam int MIN_SIZE   = 8;

   // Field widths.
   localparam int PIX_W  = 8;
   localparam int SIZE_W = 11;
   localparam int KEY_W  = 10;

   // Position and coordinate widths.
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CNT_W = COL_W + 1;
   localparam int ROW_W = $clog2(MAX_HEIGHT + HALF + 2);
   localparam int CRD_W = ((CNT_W > ROW_W) ? CNT_W : ROW_W) + 1;

   // Result queue.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
   localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 3);

   // Register port.
   localparam int DATA_W    = 32;
   localparam int REG_IDX_W = 2;
   localparam int ADDR_W    = REG_IDX_W + 2;

   localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = REG_IDX_W'(0);
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = REG_IDX_W'(1);
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD    = REG_IDX_W'(2);

   localparam logic [SIZE_W-1:0] WIDTH_RESET     = SIZE_W'(1024);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET    = SIZE_W'(1024);
   localparam logic [PIX_W-1:0]  THRESHOLD_RESET = PIX_W'(100);

   // Input item.
   typedef struct packed {
      logic             cmd;
      logic [PIX_W-1:0] pixel_response;
   } req_data_type;

   // Result item.
   typedef struct packed {
      logic [KEY_W-1:0] key_x;
      logic [KEY_W-1:0] key_y;
      logic [PIX_W-1:0] key_response;
   } rsp_data_type;

   // One window column, row 0 (oldest line) first.
   typedef logic [WINDOW-1:0][PIX_W-1:0] column_type;

   // Controls shared by every cell of the window chain.
   typedef struct packed {
      logic              shift;
      logic [WINDOW-1:0] row_mask;
      logic [PIX_W-1:0]  centre;
   } cell_ctl_type;

endpackage

// ----- rtl/window_nonmax_suppression.sv -----
// ============================================================================
// window_nonmax_suppression
// 7x7 non-maximum suppression over a raster stream of 8-bit corner responses.
// ============================================================================
// Usage:
//   Send one transfer per raster pixel on the req channel (cmd = 0), then
//   drain transfers (cmd = 1) for the last three rows plus three columns of
//   the frame. Each transfer yields zero or one keypoint on the rsp channel,
//   in stream order. Width, height and threshold are set through the APB
//   port between frames while the block is idle.
// Throughput and pipeline:
//   One transfer per cycle is taken while req_stall is low. A keypoint is
//   offered on rsp once its transfer has passed the registered line store
//   read, the registered window shift and the compare into the result queue.
//   The rate is set by the line store, read once per cycle and written once
//   per active transfer, and by the window chain, shifted a column per write.
// Stalls:
//   A four-entry result queue parts the two channels. req_stall rises when
//   items in flight plus queued results fill the queue.
// Reset:
//   Clears the stream position, the window and the result queue and restores
//   the register defaults. The line store is not cleared and needs no pass.
// ============================================================================
`include "window_nonmax_suppression_defines.svh"

module window_nonmax_suppression (
   input  logic                                clock,
   input  logic                                reset,
   // Pixel input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  wns_pkg::req_data_type               req_data,
   // Keypoint output channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output wns_pkg::rsp_data_type               rsp_data,
   // Register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [wns_pkg::ADDR_W-1:0]          paddr,
   input  logic [wns_pkg::DATA_W-1:0]          pwdata,
   output logic [wns_pkg::DATA_W-1:0]          prdata,
   output logic                                pready
);
   import wns_pkg::*;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } pos_type;

   typedef struct packed {
      logic             valid;
      logic             active;
      logic             pixel;
      logic [PIX_W-1:0] px;
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } stage1_type;

   typedef struct packed {
      logic              valid;
      logic              report;
      logic [WINDOW-1:0] rmask;
      logic [WINDOW-1:0] cmask;
      logic [KEY_W-1:0]  key_x;
      logic [KEY_W-1:0]  key_y;
   } stage2_type;

   // Moves a position to the next row past the row end, and back to the
   // frame start past the last drain position.
   function automatic pos_type wrap_pos(
      input logic [CNT_W-1:0] c,
      input logic [ROW_W-1:0] r,
      input logic [CNT_W-1:0] w,
      input logic [ROW_W-1:0] h
   );
      logic [CNT_W-1:0] cc;
      logic [ROW_W-1:0] rr;
      logic [ROW_W:0]   lim;
      pos_type          p;
      cc = c;
      rr = r;
      if (cc >= w) begin
         cc = '0;
         rr = rr + 1'b1;
      end
      lim = {1'b0, h} + (ROW_W + 1)'(HALF);
      if (({1'b0, rr} > lim) || (({1'b0, rr} == lim) && (cc >= CNT_W'(HALF)))) begin
         cc = '0;
         rr = '0;
      end
      p.col = cc[COL_W-1:0];
      p.row = rr;
      return p;
   endfunction

   // Configuration registers
   logic [SIZE_W-1:0] width_ff;
   logic [SIZE_W-1:0] width_in;
   logic [SIZE_W-1:0] height_ff;
   logic [SIZE_W-1:0] height_in;
   logic [PIX_W-1:0]  threshold_ff;
   logic [PIX_W-1:0]  threshold_in;
   logic              cfg_write;
   logic [REG_IDX_W-1:0] reg_idx;

   // Stream position and pipeline
   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic [CNT_W-1:0] w_eff;
   logic [ROW_W-1:0] h_eff;
   pos_type          pos0;
   pos_type          pos1;
   logic             accept;
   logic             drain_ign;
   stage1_type       s1_ff;
   stage1_type       s1_in;
   stage2_type       s2_ff;
   stage2_type       s2_in;
   logic [CREDIT_W-1:0] credit_used;

   // Coordinates of the judged centre
   logic signed [CRD_W-1:0] cx;
   logic signed [CRD_W-1:0] cy;
   logic signed [CRD_W-1:0] ws;
   logic signed [CRD_W-1:0] hs;

   // Line store and window chain
   logic [LINES*PIX_W-1:0] ram_rdata;
   logic [LINES*PIX_W-1:0] ram_wdata;
   logic                   ram_we;
   column_type             colv;
   column_type             cell_data [WINDOW];
   column_type             cell_feed [WINDOW];
   logic [WINDOW-1:0]      cell_exceed;
   cell_ctl_type           cell_ctl;
   logic [PIX_W-1:0]       centre;

   // Result queue
   logic                   hit;
   rsp_data_type           push_data;
   logic                   pop;
   logic [FIFO_CNT_W-1:0]  fifo_count;

   // ------------------------------------------------------------------------
   // Register port: a write lands in the access phase.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign reg_idx   = paddr[ADDR_W-1:2];

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      threshold_in = threshold_ff;
      if (cfg_write) begin
         case (reg_idx)
            REG_IMAGE_WIDTH: begin
               width_in = pwdata[SIZE_W-1:0];
            end
            REG_IMAGE_HEIGHT: begin
               height_in = pwdata[SIZE_W-1:0];
            end
            REG_THRESHOLD: begin
               threshold_in = pwdata[PIX_W-1:0];
            end
            default: begin
               width_in = width_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= WIDTH_RESET;
         height_ff    <= HEIGHT_RESET;
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         threshold_ff <= threshold_in;
      end
   end

   // Register read back.
   always_comb begin
      case (reg_idx)
         REG_IMAGE_WIDTH:  prdata = DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: prdata = DATA_W'(height_ff);
         REG_THRESHOLD:    prdata = DATA_W'(threshold_ff);
         default:          prdata = '0;
      endcase
   end

   // Sizes saturated to the supported range.
   always_comb begin
      if (width_ff < SIZE_W'(MIN_SIZE)) begin
         w_eff = CNT_W'(MIN_SIZE);
      end else if (width_ff > MAX_WIDTH) begin
         w_eff = CNT_W'(MAX_WIDTH);
      end else begin
         w_eff = CNT_W'(width_ff);
      end
      if (height_ff < SIZE_W'(MIN_SIZE)) begin
         h_eff = ROW_W'(MIN_SIZE);
      end else if (height_ff > MAX_HEIGHT) begin
         h_eff = ROW_W'(MAX_HEIGHT);
      end else begin
         h_eff = ROW_W'(height_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Input transfers are held off while the queue could overflow.
   assign credit_used = CREDIT_W'(s1_ff.valid) + CREDIT_W'(s2_ff.valid)
                        + CREDIT_W'(fifo_count);
   assign req_stall   = reset || (credit_used >= CREDIT_W'(FIFO_DEPTH));
   assign accept      = req_valid && !req_stall;

   // Position of this item, and of the next one.
   always_comb begin
      pos0      = wrap_pos({1'b0, col_ff}, row_ff, w_eff, h_eff);
      pos1      = wrap_pos({1'b0, pos0.col} + CNT_W'(1), pos0.row, w_eff, h_eff);
      drain_ign = req_data.cmd && (pos0.row < h_eff);
      col_in    = col_ff;
      row_in    = row_ff;
      if (accept) begin
         col_in = drain_ign ? pos0.col : pos1.col;
         row_in = drain_ign ? pos0.row : pos1.row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage one collects the item; the line store read is issued alongside.
   always_comb begin
      s1_in.valid  = accept;
      s1_in.active = !drain_ign;
      s1_in.pixel  = !req_data.cmd && (pos0.row < h_eff);
      s1_in.px     = req_data.pixel_response;
      s1_in.col    = pos0.col;
      s1_in.row    = pos0.row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= '0;
      end else begin
         s1_ff <= s1_in;
      end
   end

   wns_ram #(
      .WIDTH (LINES * PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s1_ff.col),
      .wr_data (ram_wdata),
      .rd_addr (pos0.col),
      .rd_data (ram_rdata)
   );

   // New window column: the stored lines plus the incoming pixel; each line
   // moves up by one on write back.
   always_comb begin
      for (int k = 0; k < LINES; k++) begin
         colv[k] = ram_rdata[k*PIX_W +: PIX_W];
      end
      colv[LINES] = s1_ff.pixel ? s1_ff.px : '0;
      for (int k = 0; k < LINES; k++) begin
         ram_wdata[k*PIX_W +: PIX_W] = colv[k+1];
      end
   end

   assign ram_we = s1_ff.valid && s1_ff.active;

   // Centre coordinates and the window cells that fall inside the image.
   always_comb begin
      logic signed [CRD_W-1:0] cx0;
      logic signed [CRD_W-1:0] cy0;
      logic signed [CRD_W-1:0] ny;
      logic signed [CRD_W-1:0] nx;
      ws  = $signed(CRD_W'(w_eff));
      hs  = $signed(CRD_W'(h_eff));
      cx0 = $signed(CRD_W'(s1_ff.col)) - CRD_W'(HALF);
      cy0 = $signed(CRD_W'(s1_ff.row)) - CRD_W'(HALF);
      if (cx0 < 0) begin
         cx = cx0 + ws;
         cy = cy0 - CRD_W'(1);
      end else begin
         cx = cx0;
         cy = cy0;
      end
      s2_in.valid  = s1_ff.valid;
      s2_in.report = s1_ff.active && (cy >= 0) && (cy < hs);
      for (int i = 0; i < WINDOW; i++) begin
         ny = cy + CRD_W'(i - HALF);
         nx = cx + CRD_W'(i - HALF);
         s2_in.rmask[i] = (ny >= 0) && (ny < hs);
         s2_in.cmask[i] = (nx >= 0) && (nx < ws);
      end
      s2_in.key_x = cx[KEY_W-1:0];
      s2_in.key_y = cy[KEY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff <= '0;
      end else begin
         s2_ff <= s2_in;
      end
   end

   // ------------------------------------------------------------------------
   // Window chain: the newest column enters at the right end.
   assign cell_ctl.shift    = ram_we;
   assign cell_ctl.row_mask = s2_ff.rmask;
   assign cell_ctl.centre   = centre;
   assign centre            = cell_data[HALF][HALF];

   for (genvar j = 0; j < WINDOW; j++) begin : g_cell
      if (j == WINDOW - 1) begin : g_head
         assign cell_feed[j] = colv;
      end else begin : g_link
         assign cell_feed[j] = cell_data[j+1];
      end

      wns_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (cell_ctl),
         .col_valid (s2_ff.cmask[j]),
         .col_in    (cell_feed[j]),
         .col_out   (cell_data[j]),
         .exceed    (cell_exceed[j])
      );
   end

   // Keypoint decision; ties with the centre are kept.
   assign hit = s2_ff.valid && s2_ff.report && (centre > threshold_ff) && !(|cell_exceed);

   always_comb begin
      push_data.key_x        = s2_ff.key_x;
      push_data.key_y        = s2_ff.key_y;
      push_data.key_response = centre;
   end

   assign pop = rsp_valid && !rsp_stall;

   wns_fifo u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (hit),
      .push_data (push_data),
      .pop       (pop),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .count     (fifo_count)
   );

   // ------------------------------------------------------------------------
   // Checks on flow control and the pipeline.
   `WNS_ASSERT_IMPL(a_credit_bound, clock, reset, 1'b1, credit_used <= CREDIT_W'(FIFO_DEPTH))
   `WNS_ASSERT_IMPL(a_push_has_room, clock, reset, hit, fifo_count < FIFO_CNT_W'(FIFO_DEPTH))
   `WNS_ASSERT_NEXT(a_accept_enters_pipe, clock, reset, accept, s1_ff.valid)
   `WNS_ASSERT_AFTER_RESET(a_reset_empties, clock, reset, !s1_ff.valid && !s2_ff.valid && !rsp_valid)

endmodule

// ----- rtl/wns_ram.sv -----
// ============================================================================
// wns_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
module wns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read of the address being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/wns_cell.sv -----
// ============================================================================
// wns_cell
// One column of the suppression window: holds its pixels, passes them on to
// the next older column, and flags any valid pixel above the centre.
// ============================================================================
module wns_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  wns_pkg::cell_ctl_type ctl,
   input  logic                  col_valid,
   input  wns_pkg::column_type   col_in,
   output wns_pkg::column_type   col_out,
   output logic                  exceed
);
   import wns_pkg::*;

   column_type data_ff;
   column_type data_in;

   // Take the newer column whenever the window moves.
   always_comb begin
      data_in = ctl.shift ? col_in : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign col_out = data_ff;

   // A pixel inside the image that is larger than the centre suppresses it.
   always_comb begin
      exceed = 1'b0;
      for (int i = 0; i < WINDOW; i++) begin
         if (ctl.row_mask[i] && col_valid && (data_ff[i] > ctl.centre)) begin
            exceed = 1'b1;
         end
      end
   end

endmodule

// ----- rtl/wns_fifo.sv -----
// ============================================================================
// wns_fifo
// Small result queue between the window pipeline and the result channel.
// ============================================================================
module wns_fifo (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  wns_pkg::rsp_data_type          push_data,
   input  logic                           pop,
   output logic                           out_valid,
   output wns_pkg::rsp_data_type          out_data,
   output logic [wns_pkg::FIFO_CNT_W-1:0] count
);
   import wns_pkg::*;

   rsp_data_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]   wr_ptr_in;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff;
   logic [FIFO_PTR_W-1:0]   rd_ptr_in;
   logic [FIFO_CNT_W-1:0]   count_ff;
   logic [FIFO_CNT_W-1:0]   count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage carries no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule
